// File: hdl/mexp_pkg.sv
// Package: shared width and field type for the modular exponentiation unit.
`default_nettype none
package mexp_pkg;
  localparam int unsigned FIELD_W = 64;
  typedef logic [FIELD_W-1:0] field_t;
endpackage
`default_nettype wire

// File: hdl/mexp_if.sv
// Interfaces: valid/ready request channels for operands and results.
`default_nettype none
interface mexp_req_if;
  import mexp_pkg::*;
  logic   valid;
  logic   ready;
  field_t base;
  field_t exponent;
  field_t modulus;
  modport source (output valid, base, exponent, modulus, input ready);
  modport sink (input valid, base, exponent, modulus, output ready);
endinterface

interface mexp_rsp_if;
  import mexp_pkg::*;
  logic   valid;
  logic   ready;
  field_t result;
  modport source (output valid, result, input ready);
  modport sink (input valid, result, output ready);
endinterface
`default_nettype wire

// File: hdl/modexp_64_unit.sv
// Top level: modular exponentiation by right-to-left square-and-multiply.
// Steps: the base is reduced bit-serially in REDUCE, then per exponent bit one CHECK state
//   plus bit-serial modular multiplies in MUL (multiply if the bit is set, square while bits remain).
//   Modulus or base below 2: straight from IDLE to DONE.
// Throughput: one request at a time; ready only in IDLE, result held until taken, next
//   request accepted in the cycle after the result is taken at the earliest.
// Reset: rst (synchronous, active high) returns the sequencer to IDLE, output invalid.
`default_nettype none
module modexp_64_unit #(
  parameter int unsigned WIDTH = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  mexp_req_if.sink   req,
  mexp_rsp_if.source rsp
);
  import mexp_pkg::*;

  localparam int unsigned CW = $clog2(WIDTH);

  typedef enum logic [2:0] {IDLE, REDUCE, CHECK, MUL, DONE} state_t;
  typedef enum logic {OP_ACC, OP_SQ} op_t;

  state_t           state;
  op_t              op;
  logic [WIDTH-1:0] acc, sq, e, n;
  // shared double-and-add multiplier
  logic [WIDTH-1:0] macc, mx, my;
  logic [CW-1:0]    bitc;
  // reduction of base: restoring bit-serial remainder
  logic [WIDTH-1:0] rem, src;

  // (x + y) mod n, x,y < n
  function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] x,
      input logic [WIDTH-1:0] y, input logic [WIDTH-1:0] m);
    logic [WIDTH-1:0] room;
    room = m - y;
    return (x >= room) ? x - room : x + y;
  endfunction

  logic [WIDTH-1:0] dbl, step_mul;
  logic [WIDTH:0]   rsh;
  always_comb begin
    dbl      = add_mod(macc, macc, n);
    step_mul = my[WIDTH-1] ? add_mod(dbl, mx, n) : dbl;
    rsh      = {rem, src[WIDTH-1]};
  end

  assign req.ready = (state == IDLE);
  assign rsp.valid = (state == DONE);
  assign rsp.result = field_t'(acc);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE: begin
          if (req.valid) begin
            n    <= req.modulus[WIDTH-1:0];
            e    <= req.exponent[WIDTH-1:0];
            src  <= req.base[WIDTH-1:0];
            rem  <= '0;
            bitc <= CW'(WIDTH-1);
            if (req.modulus[WIDTH-1:0] < WIDTH'(2)) begin
              acc   <= '0;
              state <= DONE;
            end else if (req.base[WIDTH-1:0] < WIDTH'(2)) begin
              acc   <= req.base[WIDTH-1:0];
              state <= DONE;
            end else begin
              acc   <= WIDTH'(1);
              state <= REDUCE;
            end
          end
        end
        REDUCE: begin
          // one remainder bit per cycle
          if (rsh >= {1'b0, n}) rem <= WIDTH'(rsh - {1'b0, n});
          else rem <= rsh[WIDTH-1:0];
          src <= {src[WIDTH-2:0], 1'b0};
          if (bitc == '0) state <= CHECK;
          else bitc <= bitc - 1'b1;
          if (bitc == '0) sq <= (rsh >= {1'b0, n}) ? WIDTH'(rsh - {1'b0, n})
                                                   : rsh[WIDTH-1:0];
        end
        CHECK: begin
          macc <= '0;
          bitc <= CW'(WIDTH-1);
          if (e[0]) begin
            op <= OP_ACC; mx <= acc; my <= sq; state <= MUL;
          end else if (e[WIDTH-1:1] == '0) begin
            state <= DONE;
          end else begin
            e <= e >> 1;
            op <= OP_SQ; mx <= sq; my <= sq; state <= MUL;
          end
        end
        MUL: begin
          if (bitc == '0) begin
            macc <= '0;
            bitc <= CW'(WIDTH-1);
            if (op == OP_ACC) begin
              acc <= step_mul;
              if (e[WIDTH-1:1] == '0) begin
                state <= DONE;
              end else begin
                e <= e >> 1;
                op <= OP_SQ; mx <= sq; my <= sq;
              end
            end else begin
              sq    <= step_mul;
              state <= CHECK;
            end
          end else begin
            macc <= step_mul;
            my   <= my << 1;
            bitc <= bitc - 1'b1;
          end
        end
        DONE: begin
          if (rsp.ready) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: tb/tb_modexp_64_unit.sv
// Testbench for the modular exponentiation unit: directed table plus random requests.
`default_nettype none
module tb_modexp_64_unit;
  import mexp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WIDTH = 64;
  // Bound for the worst request (all-ones exponent), plus a receiver stall.
  localparam int unsigned IDLE_LIMIT = 50000;
  localparam int unsigned RANDOM_REQS = 80;
  localparam int unsigned TAIL_CYCLES = 20;

  // One directed row; chk marks a result that can be typed in by hand.
  typedef struct {
    field_t base;
    field_t exponent;
    field_t modulus;
    bit     chk;
    field_t result;
  } vec_t;

  logic clk;
  logic rst;
  mexp_req_if req ();
  mexp_rsp_if rsp ();

  modexp_64_unit #(.WIDTH(WIDTH)) uut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  field_t pending_results[$];
  int     error_count = 0;
  int     idle_cycles = 0;
  bit     stim_done = 0;

  localparam field_t ALL1 = '1;
  localparam field_t MSB1 = field_t'(1) << (WIDTH - 1);

  // Directed rows: degenerate moduli, trivial bases, zero exponent, extremes.
  vec_t dir_table[] = '{
    '{64'd0,   64'd0,   64'd0,   1, 64'd0},   // modulus zero
    '{ALL1,    ALL1,    64'd1,   1, 64'd0},   // modulus one
    '{64'd0,   64'd0,   64'd7,   1, 64'd0},   // zero to the zero
    '{64'd0,   ALL1,    ALL1,    1, 64'd0},   // base zero
    '{64'd1,   ALL1,    64'd13,  1, 64'd1},   // base one, no reduction
    '{64'd1,   64'd5,   ALL1,    1, 64'd1},
    '{64'd5,   64'd0,   64'd13,  1, 64'd1},   // exponent zero
    '{ALL1,    64'd0,   ALL1,    1, 64'd1},
    '{64'd2,   64'd10,  64'd1000,1, 64'd24},
    '{64'd3,   64'd4,   64'd7,   1, 64'd4},
    '{64'd13,  64'd1,   64'd13,  1, 64'd0},   // base equals modulus
    '{64'd20,  64'd1,   64'd7,   1, 64'd6},   // base above modulus
    '{ALL1,    64'd1,   ALL1,    1, 64'd0},
    '{ALL1,    64'd1,   64'd2,   1, 64'd1},
    '{64'd2,   64'd63,  ALL1,    1, MSB1},
    '{ALL1,    ALL1,    ALL1,    0, 64'd0},   // full-width everything
    '{ALL1-1,  ALL1,    ALL1,    0, 64'd0},
    '{MSB1,    ALL1,    MSB1+1,  0, 64'd0},
    '{64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 64'hffff_ffff_ffff_ffc5, 0, 64'd0},
    '{64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 64'h8000_0000_0000_001d, 0, 64'd0},
    '{64'd7,   MSB1,    64'd1_000_000_007, 0, 64'd0}
  };

  // (x * y) mod n by shift-and-add; x, y < n.
  function automatic field_t mulmod(field_t x, field_t y, field_t n);
    logic [WIDTH:0] acc;
    acc = '0;
    for (int i = WIDTH - 1; i >= 0; i--) begin
      acc = acc << 1;
      if (acc >= n) acc = acc - n;
      if (y[i]) begin
        acc = acc + x;
        if (acc >= n) acc = acc - n;
      end
    end
    return acc[WIDTH-1:0];
  endfunction

  // Right-to-left square-and-multiply with the block's special cases.
  function automatic field_t powmod(field_t a, field_t e, field_t n);
    field_t acc;
    field_t sq;
    if (n < 2) return '0;
    if (a < 2) return a;
    acc = 1;
    sq = a % n;
    forever begin
      if (e[0]) acc = mulmod(acc, sq, n);
      e = e >> 1;
      if (e == 0) break;
      sq = mulmod(sq, sq, n);
    end
    return acc;
  endfunction

  function automatic field_t rand_field();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Send one request after a random gap; the expectation is queued at acceptance.
  task automatic send_req(field_t a, field_t e, field_t n, bit chk, field_t res);
    int gap;
    gap = $urandom_range(0, 19);
    if ($urandom_range(0, 3) == 0) gap = 0;  // back-to-back stretches
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.valid    <= 1'b1;
    req.base     <= a;
    req.exponent <= e;
    req.modulus  <= n;
    do @(posedge clk); while (!req.ready);
    pending_results.push_back(chk ? res : powmod(a, e, n));
    @(negedge clk);
  endtask

  // Sender
  initial begin
    field_t a, e, n;
    req.valid = 0;
    req.base = '0;
    req.exponent = '0;
    req.modulus = '0;
    rst = 1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    foreach (dir_table[i])
      send_req(dir_table[i].base, dir_table[i].exponent, dir_table[i].modulus,
               dir_table[i].chk, dir_table[i].result);
    req.valid <= 1'b0;

    // Hold off until the unit has drained every outstanding request.
    wait (pending_results.size() == 0);
    @(negedge clk);

    for (int i = 0; i < RANDOM_REQS; i++) begin
      a = rand_field();
      n = rand_field();
      // Mostly short exponents to keep the run brief; some full width.
      case ($urandom_range(0, 9))
        0, 1:    e = rand_field();
        2:       e = field_t'($urandom_range(0, 3));
        default: e = field_t'($urandom_range(0, 65535));
      endcase
      case ($urandom_range(0, 9))
        0: n = field_t'($urandom_range(0, 3));
        1: n = ALL1 - field_t'($urandom_range(0, 100));
        2: n = {32'd0, $urandom()};
        default: ;
      endcase
      if ($urandom_range(0, 9) == 0) a = field_t'($urandom_range(0, 2));
      else if ($urandom_range(0, 9) == 0) a = n + field_t'($urandom_range(0, 5));
      send_req(a, e, n, 1'b0, '0);
    end
    req.valid <= 1'b0;
    stim_done = 1;
  end

  // Receiver: random stall per result, compared at the accepting edge.
  initial begin
    int stall;
    rsp.ready = 0;
    forever begin
      stall = $urandom_range(0, 19);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!rsp.valid || rst);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, rsp.result);
        error_count++;
      end else begin
        if (rsp.result !== pending_results[0]) begin
          $display("%0t: result mismatch expected %h actual %h", $time,
                   pending_results[0], rsp.result);
          error_count++;
        end
        void'(pending_results.pop_front());
      end
      @(negedge clk);
    end
  end

  // Watchdog: cycles with no handshake on either channel.
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // End of run once everything has been drained.
  initial begin
    wait (stim_done && pending_results.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
